FILE: rtl/assert_macros.svh
// Assertion macros used by the RTL of the heap queue.
// Define ASSERT_OFF to compile every assertion out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("heap queue property violated");
// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("heap queue forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

FILE: rtl/bmhq_pkg.sv
// Package of the binary min-heap queue: field widths, defaults and codes.
// No dependencies; imported by binary_min_heap_queue.
package bmhq_pkg;

    localparam int DEPTH_DEF        = 1024;
    localparam int PAYLOAD_BITS_DEF = 16;

    localparam int COST_W  = 32;
    localparam int LIMIT_W = 11;
    localparam int OCC_W   = 11;
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;

    localparam logic [LIMIT_W-1:0]        LIMIT_RESET = 11'd1024;
    localparam logic signed [COST_W-1:0]  COST_EMPTY  = 32'sh7FFF_FFFF;
    localparam logic [PADDR_W-1:0]        ADDR_HEAP_LIMIT = 2'd0;

    typedef enum logic [1:0] {
        ACT_PUSH  = 2'd0,
        ACT_POP   = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

endpackage

FILE: rtl/binary_min_heap_queue.sv
// Binary min-heap priority queue. One item is taken when start is high and
// busy is low; its single result appears on the result ports for exactly one
// cycle with done high, and the receiver cannot hold it off. Clear, a refused
// push, a pop of an empty heap, an unused action code and a push into an
// empty heap answer in the next cycle. A push into a non-empty heap stays busy
// while its entry climbs level by level, and raises done once it is placed.
// A pop shows the root as its result with done high; when entries remain it
// stays busy while the moved entry descends level by level. At each level the
// store data read in the cycle before is compared, one write lands and the
// next read is issued at once. The store is never cleared; only slots below
// the entry count are used. heap_limit (APB offset 0, reset 1024) caps pushes
// at min(heap_limit, DEPTH).
`include "assert_macros.svh"

module binary_min_heap_queue
    import bmhq_pkg::*;
#(
    parameter int DEPTH        = DEPTH_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // command side
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               action,
    input  logic signed [COST_W-1:0] cost,
    input  logic [PAYLOAD_BITS-1:0]  payload,
    // result side
    output logic                     done,
    output logic                     success,
    output logic signed [COST_W-1:0] popped_cost,
    output logic [PAYLOAD_BITS-1:0]  popped_payload,
    output logic [OCC_W-1:0]         occupancy,
    // configuration
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [PDATA_W-1:0]       pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CH_W   = ADDR_W + 2;

    typedef struct packed {
        logic signed [COST_W-1:0]    cost;
        logic [PAYLOAD_BITS-1:0]     tag;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_PLACE,
        S_POP,
        S_DN
    } state_t;

    // entry store
    entry_t              mem [DEPTH];
    logic [ADDR_W-1:0]   rd_a_addr;
    logic [ADDR_W-1:0]   rd_b_addr;
    entry_t              rd_a_q;
    entry_t              rd_b_q;
    logic                mem_we;
    logic [ADDR_W-1:0]   wa;
    entry_t              wd;

    // control and result registers
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [ADDR_W-1:0]   hole_reg, hole_next;
    entry_t              item_reg, item_next;
    logic                lv_reg, lv_next;
    logic                rv_reg, rv_next;
    logic                done_reg, done_next;
    logic                success_reg, success_next;
    logic signed [COST_W-1:0] pcost_reg, pcost_next;
    logic [PAYLOAD_BITS-1:0]  ppay_reg, ppay_next;
    logic [OCC_W-1:0]    occ_reg, occ_next;

    entry_t              in_entry;
    logic                accept;
    logic                full;
    logic                issue_up;
    logic                issue_dn;
    logic                issue_pop;
    logic                pick_l;
    logic                pick_r;
    logic [ADDR_W-1:0]   par_cur;
    logic [ADDR_W-1:0]   par_nxt;
    logic [CH_W-1:0]     cur_l, cur_r;
    logic [CH_W-1:0]     nxt_l, nxt_r;

    assign in_entry = {cost, payload};
    assign busy     = (state_reg != S_IDLE);
    assign accept   = start && !busy;
    assign full     = (32'(cnt_reg) >= 32'(limit_reg)) || (32'(cnt_reg) >= 32'(DEPTH));

    assign par_cur = (hole_reg - 1'b1) >> 1;
    assign cur_l   = CH_W'({hole_reg, 1'b1});
    assign cur_r   = cur_l + 1'b1;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_HEAP_LIMIT) ? PDATA_W'(limit_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr == ADDR_HEAP_LIMIT)
        begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // entry store: one write port, two read ports, registered read latency
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wa] <= wd;
        end
        rd_a_q <= mem[rd_a_addr];
        rd_b_q <= mem[rd_b_addr];
    end

    // ------------------------------------------------------------------
    // sift control
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        hole_next    = hole_reg;
        item_next    = item_reg;
        lv_next      = lv_reg;
        rv_next      = rv_reg;
        done_next    = 1'b0;
        success_next = success_reg;
        pcost_next   = pcost_reg;
        ppay_next    = ppay_reg;
        occ_next     = occ_reg;
        mem_we       = 1'b0;
        wa           = hole_reg;
        wd           = item_reg;
        issue_up     = 1'b0;
        issue_dn     = 1'b0;
        issue_pop    = 1'b0;
        pick_l       = 1'b0;
        pick_r       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    done_next    = 1'b1;
                    success_next = 1'b0;
                    pcost_next   = COST_EMPTY;
                    ppay_next    = '0;
                    case (action)
                        ACT_PUSH:
                        begin
                            if (!full)
                            begin
                                success_next = 1'b1;
                                cnt_next     = cnt_reg + 1'b1;
                                if (cnt_reg == '0)
                                begin
                                    mem_we = 1'b1;
                                    wa     = '0;
                                    wd     = in_entry;
                                end
                                else
                                begin
                                    // hold the new entry; the hole starts at the tail
                                    done_next  = 1'b0;
                                    item_next  = in_entry;
                                    hole_next  = cnt_reg[ADDR_W-1:0];
                                    issue_up   = 1'b1;
                                    state_next = S_UP;
                                end
                            end
                        end
                        ACT_POP:
                        begin
                            if (cnt_reg != '0)
                            begin
                                cnt_next   = cnt_reg - 1'b1;
                                done_next  = 1'b0;
                                issue_pop  = 1'b1;
                                state_next = S_POP;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            success_next = 1'b1;
                            cnt_next     = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                    occ_next = OCC_W'(cnt_next);
                end
            end

            S_UP:
            begin
                mem_we = 1'b1;
                wa     = hole_reg;
                if ($signed(item_reg.cost) < $signed(rd_a_q.cost))
                begin
                    // move the parent down, climb one level
                    wd        = rd_a_q;
                    hole_next = par_cur;
                    if (par_cur == '0)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        issue_up = 1'b1;
                    end
                end
                else
                begin
                    wd         = item_reg;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_PLACE:
            begin
                mem_we     = 1'b1;
                wa         = hole_reg;
                wd         = item_reg;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_POP:
            begin
                // root is the answer, the old tail sifts down from the root
                item_next    = rd_b_q;
                done_next    = 1'b1;
                success_next = 1'b1;
                pcost_next   = rd_a_q.cost;
                ppay_next    = rd_a_q.tag;
                occ_next     = OCC_W'(cnt_reg);
                if (cnt_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    hole_next  = '0;
                    issue_dn   = 1'b1;
                    state_next = S_DN;
                end
            end

            S_DN:
            begin
                pick_l = lv_reg && ($signed(rd_a_q.cost) < $signed(item_reg.cost));
                pick_r = rv_reg && ($signed(rd_b_q.cost) <
                         (pick_l ? $signed(rd_a_q.cost) : $signed(item_reg.cost)));
                mem_we = 1'b1;
                wa     = hole_reg;
                if (pick_r)
                begin
                    wd        = rd_b_q;
                    hole_next = cur_r[ADDR_W-1:0];
                    issue_dn  = 1'b1;
                end
                else if (pick_l)
                begin
                    wd        = rd_a_q;
                    hole_next = cur_l[ADDR_W-1:0];
                    issue_dn  = 1'b1;
                end
                else
                begin
                    wd         = item_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // read addresses for the next level; the slot written this cycle is
        // never among them, so no forwarding is needed
        par_nxt   = (hole_next - 1'b1) >> 1;
        nxt_l     = CH_W'({hole_next, 1'b1});
        nxt_r     = nxt_l + 1'b1;
        rd_a_addr = '0;
        rd_b_addr = '0;
        if (issue_up)
        begin
            rd_a_addr = par_nxt;
        end
        if (issue_pop)
        begin
            rd_b_addr = cnt_next[ADDR_W-1:0];
        end
        if (issue_dn)
        begin
            rd_a_addr = nxt_l[ADDR_W-1:0];
            rd_b_addr = nxt_r[ADDR_W-1:0];
            lv_next   = nxt_l < CH_W'(cnt_next);
            rv_next   = nxt_r < CH_W'(cnt_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            hole_reg    <= '0;
            item_reg    <= '0;
            lv_reg      <= 1'b0;
            rv_reg      <= 1'b0;
            done_reg    <= 1'b0;
            success_reg <= 1'b0;
            pcost_reg   <= COST_EMPTY;
            ppay_reg    <= '0;
            occ_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            hole_reg    <= hole_next;
            item_reg    <= item_next;
            lv_reg      <= lv_next;
            rv_reg      <= rv_next;
            done_reg    <= done_next;
            success_reg <= success_next;
            pcost_reg   <= pcost_next;
            ppay_reg    <= ppay_next;
            occ_reg     <= occ_next;
        end
    end

    assign done           = done_reg;
    assign success        = success_reg;
    assign popped_cost    = pcost_reg;
    assign popped_payload = ppay_reg;
    assign occupancy      = occ_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `ASSERT_PROP(a_clear_beat, clk, rst_n, (accept && action == ACT_CLEAR) |=> (done && success && occupancy == '0))
    `ASSERT_PROP(a_accept_progress, clk, rst_n, accept |=> (done || busy))
    `ASSERT_PROP(a_write_below_count, clk, rst_n, mem_we |=> ($past(wa) < cnt_reg))
    `ASSERT_NEVER(a_climb_past_root, clk, rst_n, state_reg == S_UP && hole_reg == '0)
    `ASSERT_NEVER(a_count_over_depth, clk, rst_n, 32'(cnt_reg) > 32'(DEPTH))

endmodule
